[rtl/tgm_pkg.sv]
// Shared types and constants for the touchpad gesture to mouse report block.
// Used by every module under rtl/; depends on nothing.
package tgm_pkg;

  typedef struct packed {
    logic               feature_request;
    logic               sensor_ready;
    logic [7:0]         finger_count;
    logic signed [15:0] abs_x;
    logic signed [15:0] abs_y;
  } tgm_poll_t;

  typedef struct packed {
    logic              send_report;
    logic [2:0]        buttons;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel;
  } tgm_report_t;

  // Classified poll handed from front to back. dx/dy are only meaningful
  // when move_ok is set, and then they fit in 8 bits.
  typedef struct packed {
    logic              send_report;
    logic [2:0]        buttons;
    logic              wheeling;
    logic              move_ok;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } tgm_cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_TAP_MAX_TICKS = 2'd0;
  localparam logic [1:0] REG_JUMP_LIMIT    = 2'd1;
  localparam logic [1:0] REG_SETTLE_TICKS  = 2'd2;

  localparam logic [7:0] TAP_MAX_TICKS_RST = 8'd6;
  localparam logic [6:0] JUMP_LIMIT_RST    = 7'd80;
  localparam logic [7:0] SETTLE_TICKS_RST  = 8'd4;

  // Peak finger counts that pick a mode
  localparam logic [7:0] FINGERS_ONE   = 8'd1;
  localparam logic [7:0] FINGERS_LEFT  = 8'd2;
  localparam logic [7:0] FINGERS_WHEEL = 8'd3;
  localparam logic [7:0] FINGERS_RIGHT = 8'd4;

  localparam logic [2:0] BTN_LEFT   = 3'b001;
  localparam logic [2:0] BTN_RIGHT  = 3'b010;
  localparam logic [2:0] BTN_MIDDLE = 3'b100;

  // Front-to-back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

[rtl/touchpad_gesture_to_mouse_report.sv]
// Top level of the touchpad gesture to mouse report block: front, queue, back.
// Depends on tgm_pkg, tgm_front, tgm_queue, tgm_back.
//
//   channel  direction  handshake        word
//   poll     in         push / full      tgm_poll_t
//   report   out        pop / empty      tgm_report_t
//   config   in         cfg_write        cfg_index, cfg_data
//
// One poll per cycle sustained while reports are popped. The front updates
// touch state as the poll is taken; its command is registered in a queue
// slot, and the back scales motion on the way into the output register.
// Synchronous reset clears touch state, loads config defaults, empties queues.
// With the output held, the two-word queue fills and full rises.
module touchpad_gesture_to_mouse_report (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  tgm_pkg::tgm_poll_t   poll,
  output logic                empty,
  input  logic                pop,
  output tgm_pkg::tgm_report_t report,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic              accept;
  tgm_pkg::tgm_cmd_t  front_cmd;
  tgm_pkg::tgm_cmd_t  back_cmd;
  logic              q_empty;
  logic              q_take;

  assign accept = push && !full;

  tgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .poll      (poll),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd)
  );

  tgm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_cmd),
    .full    (full),
    .rd      (q_take),
    .rd_data (back_cmd),
    .empty   (q_empty)
  );

  tgm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (back_cmd),
    .cmd_take  (q_take),
    .report    (report),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

[rtl/tgm_front.sv]
// Front end: accepts polls, holds touch state and config registers, and
// classifies each poll into a command word. Depends on tgm_pkg.
module tgm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tgm_pkg::tgm_poll_t poll,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output tgm_pkg::tgm_cmd_t  cmd
);

  logic [7:0]         tap_max_ticks;
  logic [6:0]         jump_limit;
  logic [7:0]         settle_ticks;

  logic signed [15:0] prev_x, prev_x_next;
  logic signed [15:0] prev_y, prev_y_next;
  logic [7:0]         touch_ticks, touch_ticks_next;
  logic [7:0]         peak_fingers, peak_fingers_next;
  logic               lift_pending, lift_pending_next;

  logic signed [16:0] dx, dy, clip_s;
  logic [7:0]         tick1, tick2, peak_n;
  logic               in_range, short_tap;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  always_comb begin
    dx       = {poll.abs_x[15], poll.abs_x} - {prev_x[15], prev_x};
    dy       = {poll.abs_y[15], poll.abs_y} - {prev_y[15], prev_y};
    clip_s   = $signed({10'b0, jump_limit});
    in_range = (dx < clip_s) && (dx >= -clip_s) && (dy < clip_s) && (dy >= -clip_s);
    tick1    = sat_inc(touch_ticks);
    tick2    = tick1;
    peak_n   = (peak_fingers < poll.finger_count) ? poll.finger_count : peak_fingers;
    short_tap = (touch_ticks != 8'd0) && (touch_ticks <= tap_max_ticks);

    cmd                = '0;
    prev_x_next        = prev_x;
    prev_y_next        = prev_y;
    touch_ticks_next   = touch_ticks;
    peak_fingers_next  = peak_fingers;
    lift_pending_next  = lift_pending;

    if (!poll.feature_request) begin
      if (!poll.sensor_ready) begin
        cmd.send_report   = lift_pending;
        lift_pending_next = 1'b0;
      end else begin
        prev_x_next     = poll.abs_x;
        prev_y_next     = poll.abs_y;
        cmd.send_report = 1'b1;
        if (poll.finger_count != 8'd0) begin
          peak_fingers_next = peak_n;
          if (peak_n == tgm_pkg::FINGERS_LEFT) begin
            cmd.buttons = tgm_pkg::BTN_LEFT;
            tick2       = sat_inc(tick1);   // left drag counts double
          end else if (peak_n == tgm_pkg::FINGERS_WHEEL) begin
            cmd.wheeling = 1'b1;
          end else if (peak_n == tgm_pkg::FINGERS_RIGHT) begin
            cmd.buttons = tgm_pkg::BTN_RIGHT;
          end
          touch_ticks_next = tick2;
          cmd.move_ok      = in_range && (tick2 > settle_ticks);
          cmd.dx           = dx[7:0];
          cmd.dy           = dy[7:0];
        end else begin
          if (peak_fingers == tgm_pkg::FINGERS_ONE && short_tap) begin
            cmd.buttons = tgm_pkg::BTN_LEFT;
          end else if (peak_fingers == tgm_pkg::FINGERS_WHEEL && short_tap) begin
            cmd.buttons = tgm_pkg::BTN_MIDDLE;
          end
          touch_ticks_next  = 8'd0;
          peak_fingers_next = 8'd0;
          lift_pending_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_max_ticks <= tgm_pkg::TAP_MAX_TICKS_RST;
      jump_limit    <= tgm_pkg::JUMP_LIMIT_RST;
      settle_ticks  <= tgm_pkg::SETTLE_TICKS_RST;
      prev_x        <= '0;
      prev_y        <= '0;
      touch_ticks   <= '0;
      peak_fingers  <= '0;
      lift_pending  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tgm_pkg::REG_TAP_MAX_TICKS: tap_max_ticks <= cfg_data;
          tgm_pkg::REG_JUMP_LIMIT:    jump_limit    <= cfg_data[6:0];
          tgm_pkg::REG_SETTLE_TICKS:  settle_ticks  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev_x       <= prev_x_next;
        prev_y       <= prev_y_next;
        touch_ticks  <= touch_ticks_next;
        peak_fingers <= peak_fingers_next;
        lift_pending <= lift_pending_next;
      end
    end
  end

endmodule

[rtl/tgm_queue.sv]
// Short register queue of command words between front and back.
// Depends on tgm_pkg for the word type and depth.
module tgm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  tgm_pkg::tgm_cmd_t  wr_data,
  output logic              full,
  input  logic              rd,
  output tgm_pkg::tgm_cmd_t  rd_data,
  output logic              empty
);

  tgm_pkg::tgm_cmd_t                 slots [tgm_pkg::QDEPTH];
  logic [tgm_pkg::QPTR_W-1:0] wr_ptr;
  logic [tgm_pkg::QPTR_W-1:0] rd_ptr;
  logic [tgm_pkg::QCNT_W-1:0] count;

  localparam logic [tgm_pkg::QPTR_W-1:0] LAST = tgm_pkg::QPTR_W'(tgm_pkg::QDEPTH - 1);

  assign full    = (count == tgm_pkg::QCNT_W'(tgm_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/tgm_back.sv]
// Back end: scales motion and wheel of a command word and holds the
// finished report in an output register. Depends on tgm_pkg.
module tgm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  tgm_pkg::tgm_cmd_t    cmd,
  output logic                cmd_take,
  output tgm_pkg::tgm_report_t report,
  output logic                empty,
  input  logic                pop
);

  logic                out_valid;
  tgm_pkg::tgm_report_t rep_next;

  logic signed [9:0]  x3;
  logic signed [9:0]  x_half;
  logic [8:0]         dy_mag;
  logic [9:0]         y6;
  logic [17:0]        y_prod;
  logic [7:0]         y_q;
  logic signed [8:0]  y_s;
  logic [13:0]        w_prod;
  logic [4:0]         w_q;

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    // x * 3 / 2, truncated toward zero
    x3     = {{2{cmd.dx[7]}}, cmd.dx} + {cmd.dx[7], cmd.dx, 1'b0};
    x_half = (x3 + $signed({9'b0, x3[9]})) >>> 1;

    // |dy| * 6 / 5 via reciprocal: exact for the ranges used here
    dy_mag = cmd.dy[7] ? 9'(-{cmd.dy[7], cmd.dy}) : {1'b0, cmd.dy};
    y6     = {dy_mag, 1'b0} + {dy_mag, 1'b0} + {dy_mag, 1'b0};
    y_prod = 18'(y6) * 18'd205;
    y_q    = y_prod[17:10];
    y_s    = cmd.dy[7] ? -$signed({1'b0, y_q}) : $signed({1'b0, y_q});

    w_prod = 14'(dy_mag[6:0]) * 14'd103;
    w_q    = w_prod[13:9];
    if (!cmd.dy[7] && cmd.dy != 8'sd0 && w_q == 5'd0) begin
      w_q = 5'd1;   // small upward strokes still scroll one step
    end

    rep_next             = '0;
    rep_next.send_report = cmd.send_report;
    rep_next.buttons     = cmd.buttons;
    if (cmd.move_ok) begin
      if (cmd.wheeling) begin
        rep_next.wheel = cmd.dy[7] ? $signed({3'b0, w_q}) : -$signed({3'b0, w_q});
      end else begin
        if (x_half > 10'sd127) begin
          rep_next.move_x = 8'sd127;
        end else if (x_half < -10'sd128) begin
          rep_next.move_x = -8'sd128;
        end else begin
          rep_next.move_x = x_half[7:0];
        end
        if (y_s > 9'sd127) begin
          rep_next.move_y = 8'sd127;
        end else if (y_s < -9'sd128) begin
          rep_next.move_y = -8'sd128;
        end else begin
          rep_next.move_y = y_s[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      report <= rep_next;
    end
  end

endmodule
